### rtl/core/tlbpt_pkg.sv
// package: shared constants, types and state codes for the page translator
`timescale 1ns / 1ps
`default_nettype none
package tlbpt_pkg;
  localparam int TLB_ENTRIES_DEF  = 16;
  localparam int PAGE_COUNT_DEF   = 1024;
  localparam int FRAME_COUNT_DEF  = 256;
  localparam int OFFSET_WIDTH_DEF = 10;
  localparam int ADDR_W = 20;
  localparam int PHYS_W = 18;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] vaddr;
  } in_item_t;

  typedef struct packed {
    logic [PHYS_W-1:0] paddr;
    logic              tlb_hit;
    logic              page_fault;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PT,
    ST_OWN,
    ST_OLD,
    ST_UNL,
    ST_LINK,
    ST_POP,
    ST_POPL,
    ST_DONE,
    ST_INIT
  } state_t;
endpackage
`default_nettype wire

### rtl/core/tlbpt_if.sv
// valid/ready channel interface carrying one payload
`timescale 1ns / 1ps
`default_nettype none
interface tlbpt_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/tlb_page_translator_fifo_lru.sv
// Demand-paged address translator with a FIFO-replaced TLB.
// in: vaddr over a valid/ready channel; out: paddr, tlb_hit, page_fault,
// one result per input, over a valid/ready channel.
// replacement_mode (cfg_we/cfg_data): 0 round robin, 1 least recently used
// victim once all frames are used; write only while idle.
// One item at a time: a TLB hit goes from the lookup straight to the result;
// a miss reads the page table and then unlinks, appends and pops in the
// recency list, and a fault once all frames are in use first reads the owner
// of the victim frame and drops its old mapping, all set by the dependent
// reads and writes of the page table, owner map and recency-list memories.
// After reset a clearing pass over the PAGE_COUNT pages clears the page valid
// and recency member bits; no input is taken meanwhile.
// The result is held until the receiver takes it; no new item is taken
// while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_translator_fifo_lru
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_data,
  tlbpt_if.sink   in_ch,
  tlbpt_if.source out_ch
);
  logic mode;
  logic [PHYS_W-1:0] phys;
  logic hit, fault;

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_FIFO;
    else if (cfg_we) mode <= cfg_data;
  end

  tlbpt_core #(
    .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
    .FRAME_COUNT(FRAME_COUNT), .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_core (
    .clk, .rst, .mode,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .addr(in_ch.payload.vaddr),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .phys, .out_hit(hit), .out_fault(fault)
  );

  assign out_ch.payload.paddr = phys;
  assign out_ch.payload.tlb_hit = hit;
  assign out_ch.payload.page_fault = fault;
endmodule
`default_nettype wire

### rtl/core/tlbpt_tlb.sv
// fifo-replaced tlb with valid bits, lookup registered
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_tlb
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PW = 10,
  parameter int FW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          look,
  input  wire logic [PW-1:0] look_page,
  output logic               hit,
  output logic [FW-1:0]      hit_frame,
  input  wire logic          fill,
  input  wire logic [PW-1:0] fill_page,
  input  wire logic [FW-1:0] fill_frame,
  input  wire logic          drop,
  input  wire logic [PW-1:0] drop_page
);
  localparam int SW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  logic [PW-1:0] tpage [TLB_ENTRIES];
  logic [FW-1:0] tframe [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tvalid;
  logic [SW-1:0] slot;
  logic m_hit;
  logic [FW-1:0] m_frame;

  // lowest matching entry wins
  always_comb begin
    m_hit = 1'b0;
    m_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tvalid[i] && tpage[i] == look_page) begin
        m_hit = 1'b1;
        m_frame = tframe[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      hit <= m_hit;
      hit_frame <= m_frame;
    end
    if (fill) begin
      tpage[slot] <= fill_page;
      tframe[slot] <= fill_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
      slot <= '0;
    end else begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (drop && tvalid[i] && tpage[i] == drop_page) tvalid[i] <= 1'b0;
      end
      if (fill) begin
        tvalid[slot] <= 1'b1;
        slot <= (32'(slot) == TLB_ENTRIES - 1) ? '0 : slot + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/tlbpt_core.sv
// sequencer over the page table, owner map and recency-list memories
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_core
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mode,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ADDR_W-1:0] addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PHYS_W-1:0]      phys,
  output logic                   out_hit,
  output logic                   out_fault
);
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int PAW = 32 + FW + OFFSET_WIDTH;

  state_t state, state_next;

  // memories
  logic [FW-1:0] page_frame [PAGE_COUNT];
  logic          page_valid [PAGE_COUNT];
  logic [PW-1:0] owner [FRAME_COUNT];
  logic [FW-1:0] rnext [FRAME_COUNT];
  logic [FW-1:0] rprev [FRAME_COUNT];
  logic          rnext_end [FRAME_COUNT];
  logic          rprev_end [FRAME_COUNT];
  logic          rmember [FRAME_COUNT];

  logic [PW-1:0] init_cnt;
  logic [FW-1:0] rd_pf;
  logic rd_pv;
  logic [PW-1:0] rd_own;
  logic [FW-1:0] rd_n, rd_p;
  logic rd_ne, rd_pe, rd_m;

  logic [PW-1:0] page;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [FW-1:0] frame, nxt_frame;
  logic hit, fault, full;
  logic [FW:0] fill_cnt;
  logic [FW-1:0] head, tail;
  logic head_ok, tail_ok;

  logic tlb_hit;
  logic [FW-1:0] tlb_frame;
  logic tlb_fill, tlb_drop;
  logic full_now, pop_do;

  logic [FW-1:0] rd_frame_addr;
  logic [PW-1:0] rd_page_addr;

  tlbpt_tlb #(.TLB_ENTRIES(TLB_ENTRIES), .PW(PW), .FW(FW)) u_tlb (
    .clk, .rst,
    .look(state == ST_IDLE),
    .look_page(addr[OFFSET_WIDTH +: PW]),
    .hit(tlb_hit), .hit_frame(tlb_frame),
    .fill(tlb_fill), .fill_page(page), .fill_frame(frame),
    .drop(tlb_drop), .drop_page(rd_own)
  );

  always_comb begin
    rd_page_addr = page;
    if (state == ST_IDLE) rd_page_addr = addr[OFFSET_WIDTH +: PW];
    else if (state == ST_OWN) rd_page_addr = rd_own;
  end

  // in the page table step the frame is not registered yet, so address it directly
  always_comb begin
    rd_frame_addr = frame;
    if (state == ST_PT) rd_frame_addr = rd_pv ? rd_pf : nxt_frame;
    else if (state == ST_UNL || state == ST_POP) rd_frame_addr = head;
  end

  // synchronous reads, data registered
  always_ff @(posedge clk) begin
    rd_pf <= page_frame[rd_page_addr];
    rd_pv <= page_valid[rd_page_addr];
    rd_own <= owner[rd_frame_addr];
    rd_n <= rnext[rd_frame_addr];
    rd_p <= rprev[rd_frame_addr];
    rd_ne <= rnext_end[rd_frame_addr];
    rd_pe <= rprev_end[rd_frame_addr];
    rd_m <= rmember[rd_frame_addr];
  end

  // page table, owner map and member-bit writes: clearing pass, eviction, fault mapping, list membership
  always_ff @(posedge clk) begin
    if (state == ST_INIT) page_valid[init_cnt] <= 1'b0;
    else if (state == ST_OLD && full && rd_pv && rd_pf == frame) page_valid[rd_own] <= 1'b0;
    else if (state == ST_DONE && fault) begin
      page_valid[page] <= 1'b1;
      page_frame[page] <= frame;
    end
    if (state == ST_INIT) rmember[init_cnt[FW-1:0]] <= 1'b0;
    else if (state == ST_LINK) rmember[frame] <= 1'b1;
    else if (pop_do) rmember[head] <= 1'b0;
    if (state == ST_DONE && fault) owner[frame] <= page;
  end

  assign tlb_drop = (state == ST_OLD) && full && rd_pv && rd_pf == frame;
  assign tlb_fill = (state == ST_LINK);

  assign full_now = full || (32'(fill_cnt) + 1 >= FRAME_COUNT);
  // head pop only on a fault in lru mode once all frames are in use
  assign pop_do = (state == ST_POPL) && fault && full_now && mode == MODE_LRU && head_ok;

  // recency link writes: unlink of the touched frame, append, head pop
  logic unl_do;
  assign unl_do = (state == ST_UNL && rd_m) || pop_do;
  always_ff @(posedge clk) begin
    if (unl_do && !rd_pe) begin
      rnext[rd_p] <= rd_n;
      rnext_end[rd_p] <= rd_ne;
    end
    if (unl_do && !rd_ne) begin
      rprev[rd_n] <= rd_p;
      rprev_end[rd_n] <= rd_pe;
    end
    if (state == ST_LINK) begin
      rprev[frame] <= tail;
      rprev_end[frame] <= !tail_ok;
      rnext_end[frame] <= 1'b1;
      if (tail_ok) begin
        rnext[tail] <= frame;
        rnext_end[tail] <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (32'(init_cnt) == PAGE_COUNT - 1) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_LOOK;
      ST_LOOK: state_next = tlb_hit ? ST_DONE : ST_PT;
      ST_PT: state_next = rd_pv ? ST_UNL : (full ? ST_OWN : ST_UNL);
      ST_OWN: state_next = ST_OLD;
      ST_OLD: state_next = ST_UNL;
      ST_UNL: state_next = ST_LINK;
      ST_LINK: state_next = ST_POP;
      ST_POP: state_next = ST_POPL;
      ST_POPL: state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
  end

  logic [PAW-1:0] pa;
  assign pa = (PAW'(frame) << OFFSET_WIDTH) | PAW'(offset);
  assign phys = pa[PHYS_W-1:0];
  assign out_hit = hit;
  assign out_fault = fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      init_cnt <= '0;
      nxt_frame <= '0;
      fill_cnt <= '0;
      full <= 1'b0;
      head_ok <= 1'b0;
      tail_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) init_cnt <= init_cnt + 1'b1;
      case (state)
        ST_IDLE: if (in_valid) begin
          page <= addr[OFFSET_WIDTH +: PW];
          offset <= addr[OFFSET_WIDTH-1:0];
        end
        ST_LOOK: begin
          hit <= tlb_hit;
          fault <= 1'b0;
          frame <= tlb_frame;
        end
        ST_PT: begin
          if (rd_pv) frame <= rd_pf;
          else begin
            fault <= 1'b1;
            frame <= nxt_frame;
          end
        end
        ST_UNL: if (rd_m) begin
          if (rd_pe) begin
            head <= rd_n;
            head_ok <= !rd_ne;
          end
          if (rd_ne) begin
            tail <= rd_p;
            tail_ok <= !rd_pe;
          end
        end
        ST_LINK: begin
          tail <= frame;
          tail_ok <= 1'b1;
          if (!tail_ok) begin
            head <= frame;
            head_ok <= 1'b1;
          end
        end
        ST_POPL: if (fault) begin
          if (!full) begin
            fill_cnt <= fill_cnt + 1'b1;
            if (full_now) full <= 1'b1;
          end
          if (pop_do) begin
            nxt_frame <= head;
            if (rd_pe) begin
              head <= rd_n;
              head_ok <= !rd_ne;
            end
            if (rd_ne) begin
              tail <= rd_p;
              tail_ok <= !rd_pe;
            end
          end else begin
            nxt_frame <= (32'(frame) == FRAME_COUNT - 1) ? '0 : frame + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
